>>> rtl/mdf_pkg.sv
// shared types, constants and the sigmoid table for the dense layer engine
package mdf_pkg;

   localparam int MaxLayers  = 4;
   localparam int MaxNeurons = 16;
   localparam int DataWidth  = 16;

   localparam int LayerBits  = 2;
   localparam int NeuronBits = 4;
   localparam int CountBits  = 5;
   localparam int AccWidth   = 40;
   localparam int ProdWidth  = 2 * DataWidth;
   localparam int SigWidth   = 13;

   // item kinds carried in req_tuser
   typedef enum logic [1:0] {
      MODE_LOAD_WEIGHT = 2'd0,
      MODE_LOAD_BIAS   = 2'd1,
      MODE_LOAD_INPUT  = 2'd2,
      MODE_RUN         = 2'd3
   } mode_type;

   // activation codes, one per layer
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_RELU    = 2'd1;
   localparam logic [1:0] ACT_SIGMOID = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_NUM_LAYERS  = 2'd0;
   localparam logic [1:0] REG_INPUT_COUNT = 2'd1;
   localparam logic [1:0] REG_LAYER_SIZES = 2'd2;
   localparam logic [1:0] REG_LAYER_ACTS  = 2'd3;

   typedef logic [SigWidth-1:0] sig_tab_type [256];

   // neuron count: zero reads as one, large values stop at the maximum
   function automatic logic [CountBits-1:0] clamp_count(input logic [CountBits-1:0] v);
      logic [CountBits-1:0] r;
      if (v == '0) r = CountBits'(1);
      else if (v > CountBits'(MaxNeurons)) r = CountBits'(MaxNeurons);
      else r = v;
      return r;
   endfunction

   // sigmoid table: cell centres over [-8,8), e^-1/32 steps in Q30
   function automatic sig_tab_type build_sig_table();
      sig_tab_type tab;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] q;
      int m;
      for (int k = 0; k < 256; k++) begin
         m = (k >= 128) ? (2 * k - 255) : (255 - 2 * k);
         p = 64'd1 << 30;
         for (int i = 0; i < 255; i++) begin
            if (i < m) p = (p * 64'd1040706261 + (64'd1 << 29)) >> 30;
         end
         den = (64'd1 << 30) + p;
         num = (p << 12) + (den >> 1);
         rem = '0;
         q = '0;
         // restoring division, one bit a pass
         for (int b = 47; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem = rem - den;
               q[b] = 1'b1;
            end
         end
         tab[k] = (k >= 128) ? SigWidth'(64'd4096 - q) : SigWidth'(q);
      end
      return tab;
   endfunction

   localparam sig_tab_type SigTable = build_sig_table();

endpackage

>>> rtl/mlp_dense_forward_unit.sv
// dense multilayer perceptron engine: stores, mac sequencer and result port
//
// Usage: items arrive on the req_ stream. req_tuser holds the kind: load
// weight, load bias, load input value or run. A load item is taken while
// idle and writes one store entry; it gives no result. A run item walks
// every configured layer with one shared 16x16 multiplier and a 40-bit
// accumulator, one weight per cycle, then sends the final layer's outputs on
// the rsp_ stream in neuron order, tlast on the last one.
// Steps of a run: each neuron passes weight issue, pipeline drain, bias,
// round and activation; each output passes buffer read, output load and
// send, and waits out any receiver stall. req_tready is low for the whole
// run.
// The csr_ port writes the four layout registers and is always ready. The
// user must use it only while the block is idle; the block does not enforce it.
// Reset (synchronous, high) returns the sequencer to idle and the registers
// to their defaults; store contents are kept as they are.
// A stalled receiver holds the current result in the output register until
// rsp_tready rises.
module mlp_dense_forward_unit
   import mdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] layer_index, [5:2] neuron_index, [9:6] weight_index, [25:10] value
   input  logic [31:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] result_value, [19:16] result_index
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MAC   = 9'b000000010,
      ST_DRAIN = 9'b000000100,
      ST_BIAS  = 9'b000001000,
      ST_ROUND = 9'b000010000,
      ST_ACT   = 9'b000100000,
      ST_ORD   = 9'b001000000,
      ST_OLD   = 9'b010000000,
      ST_OSEND = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [2:0]  num_layers_ff;
   logic [4:0]  input_count_ff;
   logic [19:0] layer_sizes_ff;
   logic [7:0]  layer_acts_ff;

   // sequencer counters
   logic [LayerBits-1:0]  layer_ff, layer_in;
   logic [LayerBits-1:0]  last_layer_ff, last_layer_in;
   logic [NeuronBits-1:0] neuron_ff, neuron_in;
   logic [NeuronBits-1:0] wt_ff, wt_in;
   logic [CountBits-1:0]  prev_ff, prev_in;

   // datapath
   logic                        issue_vld_ff;
   logic                        prod_vld_ff;
   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [AccWidth-1:0]  acc_ff;
   logic signed [DataWidth-1:0] sat_ff;
   logic                        rsp_valid_ff;
   logic [DataWidth-1:0]        rsp_value_ff;
   logic [NeuronBits-1:0]       rsp_index_ff;
   logic                        rsp_last_ff;

   // request fields
   logic [1:0]            f_layer;
   logic [NeuronBits-1:0] f_neuron;
   logic [NeuronBits-1:0] f_weight;
   logic [DataWidth-1:0]  f_value;
   logic                  req_acc;
   logic                  rsp_acc;

   assign f_layer  = req_tdata[1:0];
   assign f_neuron = req_tdata[5:2];
   assign f_weight = req_tdata[9:6];
   assign f_value  = req_tdata[25:10];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_valid_ff && rsp_tready;
   assign csr_ready = 1'b1;

   // per-layer size and activation of the current layer
   logic [CountBits-1:0] size_cur;
   logic [1:0]           act_cur;
   logic [LayerBits-1:0] layers_m1;

   assign size_cur = clamp_count(layer_sizes_ff[5*layer_ff +: 5]);
   assign act_cur  = layer_acts_ff[2*layer_ff +: 2];
   always_comb begin
      if (num_layers_ff == 3'd0) layers_m1 = '0;
      else if (num_layers_ff > 3'(MaxLayers)) layers_m1 = LayerBits'(MaxLayers - 1);
      else layers_m1 = LayerBits'(num_layers_ff - 3'd1);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_layers_ff  <= 3'd2;
         input_count_ff <= 5'd2;
         layer_sizes_ff <= 20'd34;
         layer_acts_ff  <= 8'd9;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_NUM_LAYERS:  num_layers_ff  <= csr_data[2:0];
            REG_INPUT_COUNT: input_count_ff <= csr_data[4:0];
            REG_LAYER_SIZES: layer_sizes_ff <= csr_data;
            REG_LAYER_ACTS:  layer_acts_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // stores
   logic [DataWidth-1:0] wt_rd, bias_rd, inp_rd, buf_rd;
   logic                 buf_we;
   logic [DataWidth-1:0] act_out;
   logic [4:0]           buf_rd_addr;

   mdf_ram #(.WIDTH(DataWidth), .DEPTH(MaxLayers * MaxNeurons * MaxNeurons)) u_weight_ram (
      .clock   (clock),
      .wr_en   (req_acc && req_tuser == MODE_LOAD_WEIGHT),
      .wr_addr ({f_layer, f_neuron, f_weight}),
      .wr_data (f_value),
      .rd_addr ({layer_ff, neuron_ff, wt_ff}),
      .rd_data (wt_rd)
   );

   mdf_ram #(.WIDTH(DataWidth), .DEPTH(MaxLayers * MaxNeurons)) u_bias_ram (
      .clock   (clock),
      .wr_en   (req_acc && req_tuser == MODE_LOAD_BIAS),
      .wr_addr ({f_layer, f_neuron}),
      .wr_data (f_value),
      .rd_addr ({layer_ff, neuron_ff}),
      .rd_data (bias_rd)
   );

   mdf_ram #(.WIDTH(DataWidth), .DEPTH(MaxNeurons)) u_input_ram (
      .clock   (clock),
      .wr_en   (req_acc && req_tuser == MODE_LOAD_INPUT),
      .wr_addr (f_neuron),
      .wr_data (f_value),
      .rd_addr (wt_ff),
      .rd_data (inp_rd)
   );

   // ping-pong buffer: layer l reads half l[0] and writes the other half
   assign buf_rd_addr = (state_ff == ST_ORD) ? {~layer_ff[0], neuron_ff}
                                             : {layer_ff[0], wt_ff};

   mdf_ram #(.WIDTH(DataWidth), .DEPTH(2 * MaxNeurons)) u_layer_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr ({~layer_ff[0], neuron_ff}),
      .wr_data (act_out),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd)
   );

   // multiply-accumulate pipeline
   logic signed [DataWidth-1:0] src_val;
   assign src_val = (layer_ff == '0) ? $signed(inp_rd) : $signed(buf_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_vld_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         issue_vld_ff <= (state_ff == ST_MAC);
         prod_vld_ff  <= issue_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= src_val * $signed(wt_rd);
   end

   logic signed [AccWidth-1:0] rnd;
   logic signed [AccWidth-13:0] shr;
   assign rnd = acc_ff + AccWidth'(2048);
   assign shr = rnd[AccWidth-1:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (state_ff != ST_MAC && state_in == ST_MAC) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + AccWidth'(prod_ff);
      end else if (state_ff == ST_BIAS) begin
         acc_ff <= acc_ff + {{(AccWidth-DataWidth-12){bias_rd[DataWidth-1]}}, bias_rd, 12'd0};
      end
   end

   // round and saturate to 16 bits
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND) begin
         if (shr > $signed((AccWidth-12)'(32767))) sat_ff <= 16'sh7fff;
         else if (shr < -$signed((AccWidth-12)'(32768))) sat_ff <= -16'sh8000;
         else sat_ff <= shr[DataWidth-1:0];
      end
   end

   // activation
   always_comb begin
      case (act_cur)
         ACT_RELU:    act_out = sat_ff[DataWidth-1] ? '0 : sat_ff;
         ACT_SIGMOID: act_out = DataWidth'(SigTable[{~sat_ff[15], sat_ff[14:8]}]);
         default:     act_out = sat_ff;
      endcase
   end
   assign buf_we = (state_ff == ST_ACT);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      layer_in      = layer_ff;
      last_layer_in = last_layer_ff;
      neuron_in     = neuron_ff;
      wt_in         = wt_ff;
      prev_in       = prev_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser == MODE_RUN) begin
               state_in      = ST_MAC;
               layer_in      = '0;
               last_layer_in = layers_m1;
               neuron_in     = '0;
               wt_in         = '0;
               prev_in       = clamp_count(input_count_ff);
            end
         end
         ST_MAC: begin
            if ({1'b0, wt_ff} == prev_ff - CountBits'(1)) state_in = ST_DRAIN;
            else wt_in = wt_ff + NeuronBits'(1);
         end
         ST_DRAIN: begin
            if (!issue_vld_ff && !prod_vld_ff) state_in = ST_BIAS;
         end
         ST_BIAS:  state_in = ST_ROUND;
         ST_ROUND: state_in = ST_ACT;
         ST_ACT: begin
            wt_in = '0;
            if ({1'b0, neuron_ff} == size_cur - CountBits'(1)) begin
               neuron_in = '0;
               if (layer_ff == last_layer_ff) begin
                  state_in = ST_ORD;
               end else begin
                  state_in = ST_MAC;
                  layer_in = layer_ff + LayerBits'(1);
                  prev_in  = size_cur;
               end
            end else begin
               state_in  = ST_MAC;
               neuron_in = neuron_ff + NeuronBits'(1);
            end
         end
         ST_ORD: state_in = ST_OLD;
         ST_OLD: state_in = ST_OSEND;
         ST_OSEND: begin
            if (rsp_acc) begin
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in  = ST_ORD;
                  neuron_in = neuron_ff + NeuronBits'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         layer_ff      <= '0;
         last_layer_ff <= '0;
         neuron_ff     <= '0;
         wt_ff         <= '0;
         prev_ff       <= CountBits'(1);
      end else begin
         state_ff      <= state_in;
         layer_ff      <= layer_in;
         last_layer_ff <= last_layer_in;
         neuron_ff     <= neuron_in;
         wt_ff         <= wt_in;
         prev_ff       <= prev_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OLD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_acc) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OLD) begin
         rsp_value_ff <= buf_rd;
         rsp_index_ff <= neuron_ff;
         rsp_last_ff  <= ({1'b0, neuron_ff} == size_cur - CountBits'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/mdf_ram.sv
// generic single-write, single-read ram with registered read data
module mdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/mlp_dense_forward_unit_test.sv
// self-checking testbench for the dense layer engine: loads, runs and register phases
module mlp_dense_forward_unit_test
   import mdf_pkg::*;
();

   localparam int CycleLimit = 1_500_000;
   localparam int ItemTarget = 460;

   typedef struct {
      mode_type         mode;
      logic [1:0]       layer;
      logic [3:0]       neuron;
      logic [3:0]       widx;
      logic signed [15:0] value;
   } net_item_type;

   typedef struct {
      logic signed [15:0] value;
      logic [3:0]         index;
      logic               last;
   } net_out_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_data = '0;

   mlp_dense_forward_unit dut (.*);

   // stimulus and scoreboard state
   net_item_type pending_items[$];
   net_out_type  neuron_outputs[$];
   net_item_type cur_item;
   int        error_count = 0;
   int        cycle_count = 0;
   int        item_count = 0;
   bit        quiet = 1'b0;

   // network copy used for prediction
   logic signed [15:0] weights [1024];
   logic signed [15:0] biases [64];
   logic signed [15:0] inputs [16];
   logic [15:0]        sig_lut [256];
   logic [2:0]         cfg_layers = 3'd2;
   logic [4:0]         cfg_inputs = 5'd2;
   logic [19:0]        cfg_sizes = 20'd34;
   logic [7:0]         cfg_acts = 8'd9;

   // generator bookkeeping: which entries hold a value
   bit        w_set [1024];
   bit        b_set [64];
   bit        i_set [16];
   int        gen_layers = 2, gen_inputs = 2;
   logic [19:0] gen_sizes = 20'd34;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int eff_count(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [15:0] activation(logic signed [15:0] x, logic [1:0] code);
      if (code == ACT_RELU) return (x < 0) ? 16'sd0 : x;
      if (code == ACT_SIGMOID) return sig_lut[(x + 17'sd32768) >> 8];
      return x;
   endfunction

   // forward pass over the configured layers
   task automatic evaluate_network();
      logic signed [15:0] prev_vals [16];
      logic signed [15:0] next_vals [16];
      logic signed [39:0] acc;
      logic signed [39:0] rounded;
      logic signed [15:0] sat;
      int layers, prev, size;
      net_out_type o;
      layers = eff_count(cfg_layers, MaxLayers);
      prev = eff_count(cfg_inputs, MaxNeurons);
      size = prev;
      for (int n = 0; n < prev; n++) prev_vals[n] = inputs[n];
      for (int l = 0; l < layers; l++) begin
         size = eff_count((cfg_sizes >> (5 * l)) & 20'h1f, MaxNeurons);
         for (int n = 0; n < size; n++) begin
            acc = 40'sd0;
            for (int w = 0; w < prev; w++)
               acc += 40'(prev_vals[w]) * 40'(weights[{l[1:0], n[3:0], w[3:0]}]);
            acc += 40'(biases[{l[1:0], n[3:0]}]) <<< 12;
            rounded = (acc + 40'sd2048) >>> 12;
            if (rounded > 40'sd32767) sat = 16'sh7fff;
            else if (rounded < -40'sd32768) sat = 16'sh8000;
            else sat = rounded[15:0];
            next_vals[n] = activation(sat, cfg_acts[2*l +: 2]);
         end
         for (int n = 0; n < size; n++) prev_vals[n] = next_vals[n];
         prev = size;
      end
      for (int n = 0; n < size; n++) begin
         o.value = prev_vals[n];
         o.index = n[3:0];
         o.last = (n == size - 1);
         neuron_outputs = {neuron_outputs, o};
      end
   endtask

   task automatic apply_item(net_item_type it);
      case (it.mode)
         MODE_LOAD_WEIGHT: weights[{it.layer, it.neuron, it.widx}] = it.value;
         MODE_LOAD_BIAS:   biases[{it.layer, it.neuron}] = it.value;
         MODE_LOAD_INPUT:  inputs[it.neuron] = it.value;
         default:          evaluate_network();
      endcase
   endtask

   // sender: one item per handshake, random gaps
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_item(cur_item);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 30)) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'b0, cur_item.value, cur_item.widx, cur_item.neuron,
                             cur_item.layer};
               req_tuser <= cur_item.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, compare against oldest expectation
   always @(posedge clock) begin
      net_out_type e;
      rsp_tready <= !reset && (quiet || $urandom_range(99) >= 30);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (neuron_outputs.size() == 0) begin
            $display("%0t: unexpected result value=%h index=%0d last=%b", $time,
                     rsp_tdata[15:0], rsp_tdata[19:16], rsp_tlast);
            error_count++;
         end else begin
            e = neuron_outputs.pop_front();
            if (rsp_tdata[15:0] !== e.value) begin
               $display("%0t: result_value expected %h actual %h", $time, e.value,
                        rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[19:16] !== e.index) begin
               $display("%0t: result_index expected %0d actual %0d", $time, e.index,
                        rsp_tdata[19:16]);
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $display("%0t: last expected %b actual %b", $time, e.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_value();
      case ($urandom_range(3))
         0: return 16'($urandom);
         3: return 16'($signed($urandom_range(16383)) - 8192);
         default: return 16'($signed($urandom_range(4095)) - 2048);
      endcase
   endfunction

   task automatic add_load(mode_type m, int l, int n, int w, logic signed [15:0] v);
      net_item_type it;
      it.mode = m;
      it.layer = l[1:0];
      it.neuron = n[3:0];
      it.widx = w[3:0];
      it.value = v;
      pending_items = {pending_items, it};
      item_count++;
      case (m)
         MODE_LOAD_WEIGHT: w_set[{it.layer, it.neuron, it.widx}] = 1'b1;
         MODE_LOAD_BIAS:   b_set[{it.layer, it.neuron}] = 1'b1;
         MODE_LOAD_INPUT:  i_set[it.neuron] = 1'b1;
         default: ;
      endcase
   endtask

   // fill every entry a run will read, then queue the run
   task automatic add_run();
      int layers, prev, size;
      layers = eff_count(gen_layers, MaxLayers);
      prev = eff_count(gen_inputs, MaxNeurons);
      for (int n = 0; n < prev; n++)
         if (!i_set[n]) add_load(MODE_LOAD_INPUT, 0, n, 0, rand_value());
      for (int l = 0; l < layers; l++) begin
         size = eff_count((gen_sizes >> (5 * l)) & 20'h1f, MaxNeurons);
         for (int n = 0; n < size; n++) begin
            if (!b_set[{l[1:0], n[3:0]}]) add_load(MODE_LOAD_BIAS, l, n, 0, rand_value());
            for (int w = 0; w < prev; w++)
               if (!w_set[{l[1:0], n[3:0], w[3:0]}])
                  add_load(MODE_LOAD_WEIGHT, l, n, w, rand_value());
         end
         prev = size;
      end
      add_load(MODE_RUN, $urandom_range(3), $urandom_range(15), $urandom_range(15),
               16'($urandom));
   endtask

   // wait until the block has nothing in flight
   task automatic drain();
      @(posedge clock);
      while (pending_items.size() > 0 || req_tvalid || neuron_outputs.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_regs(int nl, int ic, logic [19:0] sizes, logic [7:0] acts);
      logic [19:0] vals [4];
      logic [1:0]  idx [4];
      drain();
      vals = '{20'(nl), 20'(ic), sizes, 20'(acts)};
      idx = '{REG_NUM_LAYERS, REG_INPUT_COUNT, REG_LAYER_SIZES, REG_LAYER_ACTS};
      for (int r = 0; r < 4; r++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[r];
         csr_data <= vals[r];
         do @(posedge clock); while (!csr_ready);
         case (idx[r])
            REG_NUM_LAYERS:  cfg_layers = vals[r][2:0];
            REG_INPUT_COUNT: cfg_inputs = vals[r][4:0];
            REG_LAYER_SIZES: cfg_sizes = vals[r];
            default:         cfg_acts = vals[r][7:0];
         endcase
      end
      csr_valid <= 1'b0;
      gen_layers = nl[2:0];
      gen_inputs = ic[4:0];
      gen_sizes = sizes;
   endtask

   function automatic logic [19:0] rand_sizes(int hi);
      logic [19:0] s;
      for (int l = 0; l < 4; l++) s[5*l +: 5] = 5'($urandom_range(hi, 1));
      return s;
   endfunction

   // main sequence
   initial begin
      longint unsigned p, den, q;
      int m;
      // sigmoid lookup over cell centres
      for (int k = 0; k < 256; k++) begin
         m = (k >= 128) ? (2 * k - 255) : (255 - 2 * k);
         p = 64'd1 << 30;
         for (int i = 0; i < m; i++) p = (p * 64'd1040706261 + (64'd1 << 29)) >> 30;
         den = (64'd1 << 30) + p;
         q = (64'd4096 * p + den / 2) / den;
         sig_lut[k] = (k >= 128) ? 16'(64'd4096 - q) : 16'(q);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: default layout, extreme values, every kind of item
      add_load(MODE_LOAD_INPUT, 0, 0, 0, 16'sh7fff);
      add_load(MODE_LOAD_INPUT, 0, 1, 0, 16'sh8000);
      add_load(MODE_LOAD_WEIGHT, 0, 0, 0, 16'sh7fff);
      add_load(MODE_LOAD_WEIGHT, 0, 0, 1, 16'sh8000);
      add_load(MODE_LOAD_WEIGHT, 0, 1, 0, 16'sh8000);
      add_load(MODE_LOAD_WEIGHT, 0, 1, 1, 16'sh8000);
      add_load(MODE_LOAD_BIAS, 0, 0, 0, 16'sh7fff);
      add_load(MODE_LOAD_BIAS, 0, 1, 0, 16'sh8000);
      add_load(MODE_LOAD_WEIGHT, 3, 15, 15, 16'sh0000);
      add_load(MODE_LOAD_BIAS, 3, 15, 0, 16'shffff);
      add_run();
      // zero counts read as one, activation code 3 passes through
      write_regs(0, 0, 20'd0, 8'hff);
      add_run();
      // sigmoid on a single neuron, then relu
      write_regs(1, 2, 20'd1, {6'd0, ACT_SIGMOID});
      add_run();
      write_regs(1, 2, 20'd2, {6'd0, ACT_RELU});
      add_run();
      // oversized counts saturate: sixteen inputs, a sixteen-wide second layer
      write_regs(7, 31, 20'h087e1, 8'h00);
      add_run();
      write_regs(4, 16, 20'h08601, 8'hb6);
      add_run();

      // random phases with fresh layouts
      for (int ph = 0; item_count < ItemTarget; ph++) begin
         write_regs($urandom_range(4, 1), $urandom_range(6, 1),
                    ($urandom_range(9) == 0) ? rand_sizes(8) : rand_sizes(5),
                    8'($urandom));
         quiet = (ph == 1);
         for (int r = $urandom_range(6, 3); r > 0; r--) begin
            for (int j = $urandom_range(6); j > 0; j--)
               add_load(mode_type'($urandom_range(2)), $urandom_range(3), $urandom_range(15),
                        $urandom_range(15), rand_value());
            add_run();
         end
         // hold the sender until every result is back
         drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0 && neuron_outputs.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
